// ===== src/dpra_pkg.sv =====
// Shared types, widths and codes for the deformation peak/RMS autoscale block.
`default_nettype none

package dpra_pkg;

    // Input and accumulator widths
    localparam int COMP_W      = 16;
    localparam int MAX_TUPLES  = 1048576;
    localparam int CNT_W       = 21;
    localparam int MAG_W       = 16;
    localparam int SQ_W        = 32;
    localparam int SUM_W       = 52;

    // Configuration widths
    localparam int FRAC_W      = 24;
    localparam int SCALE_W     = 32;
    localparam int EXT_W       = 16;
    localparam int D2_W        = 34;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    // Iterative units
    localparam int SQ_RAD_W    = 50;
    localparam int SQ_ROOT_W   = 25;
    localparam int SQ_REM_W    = SQ_ROOT_W + 2;
    localparam int SQ_CNT_W    = $clog2(SQ_ROOT_W);
    localparam int DIV_N_W     = 52;
    localparam int DIV_D_W     = 24;
    localparam int DIV_CNT_W   = $clog2(DIV_N_W);
    localparam int PROD_W      = FRAC_W + SQ_ROOT_W;
    localparam int FRAC_SH     = 16;

    // Front-to-back queue
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

    // Stream widths
    localparam int IN_TDATA_W  = 3 * COMP_W;

    localparam logic [SCALE_W-1:0] SCALE_ONE = 32'h0001_0000;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SPAN_RATIO      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SCALE       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SCALE       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT_X        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Y        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Z        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BOUNDS_VALID    = 3'd6;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_ARGS = 2'd1,
        ST_BOUNDS   = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef struct packed {
        logic [FRAC_W-1:0]  span_ratio;
        logic [SCALE_W-1:0] min_scale;
        logic [SCALE_W-1:0] max_scale;
        logic [EXT_W-1:0]   extent_x;
        logic [EXT_W-1:0]   extent_y;
        logic [EXT_W-1:0]   extent_z;
        logic               bounds_valid;
    } cfg_t;

    // One classified vector on its way to the accumulator
    typedef struct packed {
        logic [SQ_W-1:0] m2;
        logic            fin;
        logic            last;
    } item_t;

    // Declared high field first so that tuple_total lands in the lowest bits
    typedef struct packed {
        status_t            status;
        logic [SCALE_W-1:0] scale_out;
        logic [MAG_W-1:0]   rms_mag;
        logic [MAG_W-1:0]   peak_magnitude;
        logic [CNT_W-1:0]   finite_total;
        logic [CNT_W-1:0]   tuple_total;
    } result_t;

    localparam int RESULT_W    = $bits(result_t);
    localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

    function automatic logic [COMP_W-1:0] abs_mag(input logic [COMP_W-1:0] v);
        logic [COMP_W-1:0] neg;
        neg = ~v + 1'b1;
        return v[COMP_W-1] ? neg : v;
    endfunction

endpackage

`default_nettype wire

// ===== src/deformation_peak_rms_autoscale.sv =====
// Top level: displacement set statistics with automatic deformation scale.
//
//  channel  dir  handshake                 payload
//  s_axis   in   s_axis_tvalid/tready      tdata: comp_x, comp_y, comp_z; tuser: is_finite;
//                                          tlast: last_item
//  m_axis   out  m_axis_tvalid/tready      tdata: tuple_total, finite_total, peak_magnitude,
//                                          rms_mag, scale_out, status
//  cfg      in   cfg_we                    cfg_index, cfg_wdata
//
//  One beat per cycle into a two-stage front end and a four-entry queue; the accumulator
//  drains the queue at one beat per cycle while it accumulates, and not during a finish.
//  The last beat of a set starts a finish sequence on the shared bit-serial square root
//  (used four times) and the bit-serial divider (used twice); s_axis_tready falls once
//  the queue fills.
//  A finished result waits in the output register; m_axis stalls hold only the next finish.
//  rst_n clears all control state and loads the register reset values; no clearing pass.
`default_nettype none

module deformation_peak_rms_autoscale (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // comp_x [15:0], comp_y [31:16], comp_z [47:32]
    input  wire logic [dpra_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // is_finite [0]
    input  wire logic                                s_axis_tuser,
    input  wire logic                                s_axis_tlast,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // tuple_total [20:0], finite_total [41:21], peak_magnitude [57:42],
    // rms_mag [73:58], scale_out [105:74], status [107:106], zero [111:108]
    output logic [dpra_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    input  wire logic                                cfg_we,
    input  wire logic [dpra_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [dpra_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import dpra_pkg::*;

    cfg_t    cfg_reg;
    logic    push;
    item_t   push_item;
    logic    full;
    logic    pop;
    item_t   pop_item;
    logic    empty;
    result_t result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.span_ratio      <= FRAC_W'(6554);
            cfg_reg.min_scale       <= '0;
            cfg_reg.max_scale       <= '1;
            cfg_reg.extent_x        <= '0;
            cfg_reg.extent_y        <= '0;
            cfg_reg.extent_z        <= '0;
            cfg_reg.bounds_valid    <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SPAN_RATIO:      cfg_reg.span_ratio      <= cfg_wdata[FRAC_W-1:0];
                REG_MIN_SCALE:       cfg_reg.min_scale       <= cfg_wdata[SCALE_W-1:0];
                REG_MAX_SCALE:       cfg_reg.max_scale       <= cfg_wdata[SCALE_W-1:0];
                REG_EXTENT_X:        cfg_reg.extent_x        <= cfg_wdata[EXT_W-1:0];
                REG_EXTENT_Y:        cfg_reg.extent_y        <= cfg_wdata[EXT_W-1:0];
                REG_EXTENT_Z:        cfg_reg.extent_z        <= cfg_wdata[EXT_W-1:0];
                REG_BOUNDS_VALID:    cfg_reg.bounds_valid    <= cfg_wdata[0];
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    dpra_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .comp_x    (s_axis_tdata[COMP_W-1:0]),
        .comp_y    (s_axis_tdata[2*COMP_W-1:COMP_W]),
        .comp_z    (s_axis_tdata[3*COMP_W-1:2*COMP_W]),
        .is_finite (s_axis_tuser),
        .last_item (s_axis_tlast),
        .full      (full),
        .push      (push),
        .push_item (push_item)
    );

    dpra_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (empty)
    );

    dpra_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .empty     (empty),
        .pop_item  (pop_item),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .result    (result)
    );

    assign m_axis_tdata = {(OUT_TDATA_W - RESULT_W)'(0), result};

endmodule

`default_nettype wire

// ===== src/dpra_front.sv =====
// Front end: takes vector beats, forms |x|, |y|, |z| and the squared magnitude.
`default_nettype none

module dpra_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [dpra_pkg::COMP_W-1:0]   comp_x,
    input  wire logic [dpra_pkg::COMP_W-1:0]   comp_y,
    input  wire logic [dpra_pkg::COMP_W-1:0]   comp_z,
    input  wire logic                          is_finite,
    input  wire logic                          last_item,
    input  wire logic                          full,
    output logic                               push,
    output dpra_pkg::item_t                    push_item
);
    import dpra_pkg::*;

    logic              v1_reg;
    logic              v2_reg;
    logic [COMP_W-1:0] ax_reg;
    logic [COMP_W-1:0] ay_reg;
    logic [COMP_W-1:0] az_reg;
    logic              fin1_reg;
    logic              last1_reg;
    logic [SQ_W-1:0]   sqx_reg;
    logic [SQ_W-1:0]   sqy_reg;
    logic [SQ_W-1:0]   sqz_reg;
    logic              fin2_reg;
    logic              last2_reg;
    logic              adv;

    // Whole pipe holds while the queue is full and the last stage is loaded
    assign adv      = !(v2_reg && full);
    assign in_ready = adv;
    assign push     = v2_reg && !full;

    assign push_item.m2   = sqx_reg + sqy_reg + sqz_reg;
    assign push_item.fin  = fin2_reg;
    assign push_item.last = last2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax_reg    <= abs_mag(comp_x);
            ay_reg    <= abs_mag(comp_y);
            az_reg    <= abs_mag(comp_z);
            fin1_reg  <= is_finite;
            last1_reg <= last_item;
            sqx_reg   <= ax_reg * ax_reg;
            sqy_reg   <= ay_reg * ay_reg;
            sqz_reg   <= az_reg * az_reg;
            fin2_reg  <= fin1_reg;
            last2_reg <= last1_reg;
        end
    end

endmodule

`default_nettype wire

// ===== src/dpra_fifo.sv =====
// Short queue between the front end and the accumulator, first-word fall-through.
`default_nettype none

module dpra_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire dpra_pkg::item_t push_item,
    output logic                 full,
    input  wire logic            pop,
    output dpra_pkg::item_t      pop_item,
    output logic                 empty
);
    import dpra_pkg::*;

    item_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;
    logic [FIFO_AW:0]   count_next;

    assign full     = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

`default_nettype wire

// ===== src/dpra_isqrt.sv =====
// Restoring integer square root, one root bit per cycle.
`default_nettype none

module dpra_isqrt (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [dpra_pkg::SQ_RAD_W-1:0]   radicand,
    output logic                                 done,
    output logic [dpra_pkg::SQ_ROOT_W-1:0]       root
);
    import dpra_pkg::*;

    logic                busy_reg;
    logic                done_reg;
    logic [SQ_CNT_W-1:0] cnt_reg;
    logic [SQ_RAD_W-1:0] rad_reg;
    logic [SQ_REM_W-1:0] rem_reg;
    logic [SQ_ROOT_W-1:0] root_reg;
    logic [SQ_REM_W-1:0] rem_sh;
    logic [SQ_REM_W-1:0] trial;
    logic                ge;

    // Bring down two radicand bits, try (2*root)*2 + 1
    assign rem_sh = {rem_reg[SQ_REM_W-3:0], rad_reg[SQ_RAD_W-1 -: 2]};
    assign trial  = {root_reg, 2'b01};
    assign ge     = (rem_sh >= trial);

    assign done = done_reg;
    assign root = root_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= SQ_CNT_W'(SQ_ROOT_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                    cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[SQ_RAD_W-3:0], 2'b00};
            rem_reg  <= ge ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[SQ_ROOT_W-2:0], ge};
        end
    end

endmodule

`default_nettype wire

// ===== src/dpra_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none

module dpra_div (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [dpra_pkg::DIV_N_W-1:0]   dividend,
    input  wire logic [dpra_pkg::DIV_D_W-1:0]   divisor,
    output logic                                done,
    output logic [dpra_pkg::DIV_N_W-1:0]        quotient
);
    import dpra_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_N_W-1:0]   q_reg;
    logic [DIV_D_W-1:0]   rem_reg;
    logic [DIV_D_W-1:0]   dvs_reg;
    logic [DIV_D_W:0]     rem_sh;
    logic [DIV_D_W:0]     diff;
    logic                 ge;

    // Dividend bits shift out the top while quotient bits fill from below
    assign rem_sh = {rem_reg, q_reg[DIV_N_W-1]};
    assign diff   = rem_sh - {1'b0, dvs_reg};
    assign ge     = (rem_sh >= {1'b0, dvs_reg});

    assign done     = done_reg;
    assign quotient = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_N_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                    cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[DIV_N_W-2:0], ge};
            rem_reg <= ge ? diff[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== src/dpra_back.sv =====
// Back end: per-set accumulation, end-of-set root/divide sequence, result register.
`default_nettype none

module dpra_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire dpra_pkg::cfg_t  cfg,
    input  wire logic            empty,
    input  wire dpra_pkg::item_t pop_item,
    output logic                 pop,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output dpra_pkg::result_t    result
);
    import dpra_pkg::*;

    typedef enum logic [9:0] {
        S_ACC   = 10'b00_0000_0001,
        S_PEAK  = 10'b00_0000_0010,
        S_MEAN  = 10'b00_0000_0100,
        S_RMS   = 10'b00_0000_1000,
        S_DIAG  = 10'b00_0001_0000,
        S_PEAK8 = 10'b00_0010_0000,
        S_MUL   = 10'b00_0100_0000,
        S_SCALE = 10'b00_1000_0000,
        S_CLAMP = 10'b01_0000_0000,
        S_EMIT  = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // Accumulators
    logic [SQ_W-1:0]  peak_reg,   peak_next,   peak_acc;
    logic [SUM_W-1:0] sum_reg,    sum_next,    sum_acc;
    logic [CNT_W-1:0] finite_reg, finite_next, fin_acc;
    logic [CNT_W-1:0] total_reg,  total_next,  tot_acc;
    logic             ovf_reg,    ovf_next,    ovf_acc;

    // Unit launch
    logic                sq_start_reg, sq_start_next;
    logic [SQ_RAD_W-1:0] sq_arg_reg,   sq_arg_next;
    logic                dv_start_reg, dv_start_next;
    logic [DIV_N_W-1:0]  dv_num_reg,   dv_num_next;
    logic [DIV_D_W-1:0]  dv_den_reg,   dv_den_next;

    // Finish results
    logic [MAG_W-1:0]     pmag_reg,   pmag_next;
    logic [MAG_W-1:0]     rms_reg,    rms_next;
    logic [SQ_ROOT_W-1:0] diag8_reg,  diag8_next;
    logic [DIV_D_W-1:0]   peak8_reg,  peak8_next;
    logic [DIV_N_W-1:0]   raw_reg,    raw_next;
    logic [SCALE_W-1:0]   scale_reg,  scale_next;
    logic                 out_valid_reg, out_valid_next;
    result_t              out_reg,    out_next;

    // Diagonal squared, refreshed continuously from the extents
    logic [SQ_W-1:0] ex2_reg, ey2_reg, ez2_reg;
    logic [D2_W-1:0] d2_reg;

    logic                 sq_done;
    logic [SQ_ROOT_W-1:0] sq_root;
    logic                 dv_done;
    logic [DIV_N_W-1:0]   dv_quot;

    status_t              status;
    state_t               decide_state;
    logic [PROD_W-1:0]    prod;
    logic [SCALE_W-1:0]   sat_scale;
    logic [SCALE_W-1:0]   lo_scale;
    logic                 load_out;

    dpra_isqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start_reg),
        .radicand (sq_arg_reg),
        .done     (sq_done),
        .root     (sq_root)
    );

    dpra_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dv_start_reg),
        .dividend (dv_num_reg),
        .divisor  (dv_den_reg),
        .done     (dv_done),
        .quotient (dv_quot)
    );

    assign pop       = (state_reg == S_ACC) && !empty;
    assign out_valid = out_valid_reg;
    assign result    = out_reg;
    assign load_out  = !out_valid_reg || out_ready;

    assign prod      = cfg.span_ratio * diag8_reg;
    assign sat_scale = (|raw_reg[DIV_N_W-1:SCALE_W]) ? '1 : raw_reg[SCALE_W-1:0];
    assign lo_scale  = (sat_scale < cfg.min_scale) ? cfg.min_scale : sat_scale;

    always_comb
    begin
        if (cfg.span_ratio == '0 || cfg.max_scale < cfg.min_scale)
            status = ST_BAD_ARGS;
        else if (ovf_reg)
            status = ST_OVERFLOW;
        else if (!cfg.bounds_valid)
            status = ST_BOUNDS;
        else
            status = ST_OK;
    end

    // After RMS, or peak if none finite: error ends set, zero peak/diagonal: unit scale
    always_comb
    begin
        if (status != ST_OK)
            decide_state = S_EMIT;
        else if (peak_reg == '0 || d2_reg == '0)
            decide_state = S_CLAMP;
        else
            decide_state = S_DIAG;
    end

    always_comb
    begin
        peak_acc = peak_reg;
        sum_acc  = sum_reg;
        fin_acc  = finite_reg;
        tot_acc  = total_reg;
        ovf_acc  = ovf_reg;
        if (total_reg >= CNT_W'(MAX_TUPLES))
            ovf_acc = 1'b1;
        else
        begin
            tot_acc = total_reg + 1'b1;
            if (pop_item.fin)
            begin
                if (pop_item.m2 > peak_reg)
                    peak_acc = pop_item.m2;
                sum_acc = sum_reg + SUM_W'(pop_item.m2);
                fin_acc = finite_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        peak_next      = peak_reg;
        sum_next       = sum_reg;
        finite_next    = finite_reg;
        total_next     = total_reg;
        ovf_next       = ovf_reg;
        sq_start_next  = 1'b0;
        sq_arg_next    = sq_arg_reg;
        dv_start_next  = 1'b0;
        dv_num_next    = dv_num_reg;
        dv_den_next    = dv_den_reg;
        pmag_next      = pmag_reg;
        rms_next       = rms_reg;
        diag8_next     = diag8_reg;
        peak8_next     = peak8_reg;
        raw_next       = raw_reg;
        scale_next     = scale_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            S_ACC:
            begin
                if (pop)
                begin
                    peak_next   = peak_acc;
                    sum_next    = sum_acc;
                    finite_next = fin_acc;
                    total_next  = tot_acc;
                    ovf_next    = ovf_acc;
                    if (pop_item.last)
                    begin
                        sq_start_next = 1'b1;
                        sq_arg_next   = SQ_RAD_W'(peak_acc);
                        state_next    = S_PEAK;
                    end
                end
            end
            S_PEAK:
            begin
                if (sq_done)
                begin
                    pmag_next = sq_root[MAG_W-1:0];
                    if (finite_reg == '0)
                    begin
                        rms_next      = '0;
                        scale_next    = '0;
                        raw_next      = DIV_N_W'(SCALE_ONE);
                        sq_start_next = (decide_state == S_DIAG);
                        sq_arg_next   = {d2_reg, FRAC_SH'(0)};
                        state_next    = decide_state;
                    end
                    else
                    begin
                        dv_start_next = 1'b1;
                        dv_num_next   = sum_reg;
                        dv_den_next   = DIV_D_W'(finite_reg);
                        state_next    = S_MEAN;
                    end
                end
            end
            S_MEAN:
            begin
                if (dv_done)
                begin
                    sq_start_next = 1'b1;
                    sq_arg_next   = dv_quot[SQ_RAD_W-1:0];
                    state_next    = S_RMS;
                end
            end
            S_RMS:
            begin
                if (sq_done)
                begin
                    rms_next      = sq_root[MAG_W-1:0];
                    scale_next    = '0;
                    raw_next      = DIV_N_W'(SCALE_ONE);
                    sq_start_next = (decide_state == S_DIAG);
                    sq_arg_next   = {d2_reg, FRAC_SH'(0)};
                    state_next    = decide_state;
                end
            end
            S_DIAG:
            begin
                if (sq_done)
                begin
                    diag8_next    = sq_root;
                    sq_start_next = 1'b1;
                    sq_arg_next   = SQ_RAD_W'({peak_reg, FRAC_SH'(0)});
                    state_next    = S_PEAK8;
                end
            end
            S_PEAK8:
            begin
                if (sq_done)
                begin
                    peak8_next = sq_root[DIV_D_W-1:0];
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                dv_start_next = 1'b1;
                dv_num_next   = DIV_N_W'(prod);
                dv_den_next   = peak8_reg;
                state_next    = S_SCALE;
            end
            S_SCALE:
            begin
                if (dv_done)
                begin
                    raw_next   = dv_quot;
                    state_next = S_CLAMP;
                end
            end
            S_CLAMP:
            begin
                scale_next = (lo_scale > cfg.max_scale) ? cfg.max_scale : lo_scale;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (load_out)
                begin
                    out_next.tuple_total    = total_reg;
                    out_next.finite_total   = finite_reg;
                    out_next.peak_magnitude = pmag_reg;
                    out_next.rms_mag        = rms_reg;
                    out_next.scale_out      = scale_reg;
                    out_next.status         = status;
                    out_valid_next          = 1'b1;
                    peak_next               = '0;
                    sum_next                = '0;
                    finite_next             = '0;
                    total_next              = '0;
                    ovf_next                = 1'b0;
                    state_next              = S_ACC;
                end
            end
            default:
            begin
                state_next = S_ACC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_ACC;
            peak_reg      <= '0;
            sum_reg       <= '0;
            finite_reg    <= '0;
            total_reg     <= '0;
            ovf_reg       <= 1'b0;
            sq_start_reg  <= 1'b0;
            dv_start_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            peak_reg      <= peak_next;
            sum_reg       <= sum_next;
            finite_reg    <= finite_next;
            total_reg     <= total_next;
            ovf_reg       <= ovf_next;
            sq_start_reg  <= sq_start_next;
            dv_start_reg  <= dv_start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_arg_reg <= sq_arg_next;
        dv_num_reg <= dv_num_next;
        dv_den_reg <= dv_den_next;
        pmag_reg   <= pmag_next;
        rms_reg    <= rms_next;
        diag8_reg  <= diag8_next;
        peak8_reg  <= peak8_next;
        raw_reg    <= raw_next;
        scale_reg  <= scale_next;
        out_reg    <= out_next;
        ex2_reg    <= cfg.extent_x * cfg.extent_x;
        ey2_reg    <= cfg.extent_y * cfg.extent_y;
        ez2_reg    <= cfg.extent_z * cfg.extent_z;
        d2_reg     <= D2_W'(ex2_reg) + D2_W'(ey2_reg) + D2_W'(ez2_reg);
    end

endmodule

`default_nettype wire

// ===== src/dpra_checker.sv =====
// Port-level checks on the result stream, bound to the top level.
`default_nettype none

module dpra_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    input  wire logic [dpra_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import dpra_pkg::*;

    result_t r;

    assign r = result_t'(m_axis_tdata[RESULT_W-1:0]);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat dropped or changed while stalled");

    a_err_scale: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (r.status != ST_OK) |-> (r.scale_out == '0))
        else $error("nonzero scale with error status");

    a_counts: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (r.finite_total <= r.tuple_total))
        else $error("finite count exceeds total count");

    a_rms_peak: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (r.rms_mag <= r.peak_magnitude))
        else $error("rms magnitude above peak magnitude");

endmodule

bind deformation_peak_rms_autoscale dpra_checker u_dpra_checker (.*);

`default_nettype wire

// ===== tb/sv/tb_deformation_peak_rms_autoscale.sv =====
// Testbench for deformation_peak_rms_autoscale: random stream traffic checked against a predictor.
`timescale 1ns / 100ps

module tb_deformation_peak_rms_autoscale;
    import dpra_pkg::*;

    typedef struct packed {
        logic [COMP_W-1:0] x;
        logic [COMP_W-1:0] y;
        logic [COMP_W-1:0] z;
        logic              fin;
        logic              last;
    } vec_beat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tuser = 1'b0;
    logic                   s_axis_tlast = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    deformation_peak_rms_autoscale uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always #1 clk = ~clk;

    // Stimulus and expectation stores
    vec_beat_t vec_queue[$];
    result_t   expected_stats[$];

    // Shadow configuration and running set statistics
    cfg_t             cfg_shadow;
    logic [SQ_W-1:0]  run_peak_sq = '0;
    logic [SUM_W-1:0] run_sum_sq = '0;
    logic [CNT_W-1:0] run_finite = '0;
    logic [CNT_W-1:0] run_total = '0;
    logic             run_ovf = 1'b0;

    int  mismatch_count = 0;
    int  beats_pushed = 0;
    int  beats_accepted = 0;
    int  results_seen = 0;
    int  cfg_phases = 0;
    bit  gaps_on = 1'b1;

    int  send_gap = 0;
    int  recv_stall = 0;
    int  hold_cnt = 0;
    bit  hold_done = 1'b0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        if (r < 98)
            return $urandom_range(20, 4);
        return $urandom_range(120, 30);
    endfunction

    function automatic logic [16:0] vec_mag(input logic [COMP_W-1:0] v);
        if (v[COMP_W-1])
            return 17'h10000 - {1'b0, v};
        return {1'b0, v};
    endfunction

    // Floor square root by building the root one bit at a time
    function automatic logic [63:0] floor_root(input logic [63:0] n);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int b = 26; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= n)
                r = t;
        end
        return r;
    endfunction

    task automatic account_vector(input vec_beat_t b);
        logic [63:0] m2;
        logic [63:0] d2;
        logic [63:0] diag8;
        logic [63:0] peak8;
        logic [63:0] scale;
        status_t     st;
        result_t     r;
        if (run_total >= CNT_W'(MAX_TUPLES))
            run_ovf = 1'b1;
        else
        begin
            run_total = run_total + 1'b1;
            if (b.fin)
            begin
                m2 = 64'(vec_mag(b.x)) * 64'(vec_mag(b.x)) + 64'(vec_mag(b.y)) * 64'(vec_mag(b.y))
                   + 64'(vec_mag(b.z)) * 64'(vec_mag(b.z));
                if (m2 > 64'(run_peak_sq))
                    run_peak_sq = m2[SQ_W-1:0];
                run_sum_sq = run_sum_sq + m2[SUM_W-1:0];
                run_finite = run_finite + 1'b1;
            end
        end
        if (b.last)
        begin
            if (cfg_shadow.span_ratio == '0 || cfg_shadow.max_scale < cfg_shadow.min_scale)
                st = ST_BAD_ARGS;
            else if (run_ovf)
                st = ST_OVERFLOW;
            else if (!cfg_shadow.bounds_valid)
                st = ST_BOUNDS;
            else
                st = ST_OK;
            scale = '0;
            if (st == ST_OK)
            begin
                d2 = 64'(cfg_shadow.extent_x) * 64'(cfg_shadow.extent_x)
                   + 64'(cfg_shadow.extent_y) * 64'(cfg_shadow.extent_y)
                   + 64'(cfg_shadow.extent_z) * 64'(cfg_shadow.extent_z);
                if (run_peak_sq == '0 || d2 == '0)
                    scale = 64'(SCALE_ONE);
                else
                begin
                    diag8 = floor_root(d2 << 16);
                    peak8 = floor_root(64'(run_peak_sq) << 16);
                    scale = (64'(cfg_shadow.span_ratio) * diag8) / peak8;
                    if (scale > 64'hFFFF_FFFF)
                        scale = 64'hFFFF_FFFF;
                end
                if (scale < 64'(cfg_shadow.min_scale))
                    scale = 64'(cfg_shadow.min_scale);
                if (scale > 64'(cfg_shadow.max_scale))
                    scale = 64'(cfg_shadow.max_scale);
            end
            r.tuple_total    = run_total;
            r.finite_total   = run_finite;
            r.peak_magnitude = MAG_W'(floor_root(64'(run_peak_sq)));
            r.rms_mag        = (run_finite == '0) ? '0 :
                               MAG_W'(floor_root(64'(run_sum_sq) / 64'(run_finite)));
            r.scale_out      = scale[SCALE_W-1:0];
            r.status         = st;
            expected_stats.push_back(r);
            run_peak_sq = '0;
            run_sum_sq  = '0;
            run_finite  = '0;
            run_total   = '0;
            run_ovf     = 1'b0;
        end
    endtask

    // Sender: holds a beat until taken, then offers the next one after a random gap
    always @(posedge clk)
    begin : vec_driver
        vec_beat_t b;
        if (rst_n && !(s_axis_tvalid && !s_axis_tready))
        begin
            if (send_gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (vec_queue.size() != 0)
            begin
                b = vec_queue.pop_front();
                s_axis_tdata  <= {b.z, b.y, b.x};
                s_axis_tuser  <= b.fin;
                s_axis_tlast  <= b.last;
                s_axis_tvalid <= 1'b1;
                if (gaps_on)
                    send_gap <= pick_gap();
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Input side: every accepted beat goes through the predictor
    always @(posedge clk)
    begin : vec_capture
        vec_beat_t b;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            b.x    = s_axis_tdata[COMP_W-1:0];
            b.y    = s_axis_tdata[2*COMP_W-1:COMP_W];
            b.z    = s_axis_tdata[3*COMP_W-1:2*COMP_W];
            b.fin  = s_axis_tuser;
            b.last = s_axis_tlast;
            account_vector(b);
            beats_accepted++;
        end
    end

    // Receiver: random stalls, plus one long hold-off so the input backs up
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_cnt != 0)
            begin
                m_axis_tready <= 1'b0;
                hold_cnt <= hold_cnt - 1;
            end
            else if (!hold_done && results_seen >= 25)
            begin
                hold_done <= 1'b1;
                hold_cnt <= 700;
                m_axis_tready <= 1'b0;
            end
            else if (recv_stall != 0)
            begin
                m_axis_tready <= 1'b0;
                recv_stall <= recv_stall - 1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (gaps_on)
                    recv_stall <= pick_gap();
            end
        end
    end

    task automatic report_field(input string name, input logic [63:0] exp_v,
                                input logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    // Output side: compare each result beat with the oldest prediction
    always @(posedge clk)
    begin : stats_check
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = result_t'(m_axis_tdata[RESULT_W-1:0]);
            results_seen++;
            if (expected_stats.size() == 0)
            begin
                $display("%0t: result beat with nothing expected: expected none, got %h",
                         $realtime, m_axis_tdata);
                mismatch_count++;
            end
            else
            begin
                want = expected_stats.pop_front();
                report_field("tuple_total", 64'(want.tuple_total), 64'(got.tuple_total));
                report_field("finite_total", 64'(want.finite_total), 64'(got.finite_total));
                report_field("peak_magnitude", 64'(want.peak_magnitude),
                             64'(got.peak_magnitude));
                report_field("rms_mag", 64'(want.rms_mag), 64'(got.rms_mag));
                report_field("scale_out", 64'(want.scale_out), 64'(got.scale_out));
                report_field("status", 64'(want.status), 64'(got.status));
                report_field("pad bits", 64'd0, 64'(m_axis_tdata[OUT_TDATA_W-1:RESULT_W]));
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_SPAN_RATIO:      cfg_shadow.span_ratio      = val[FRAC_W-1:0];
            REG_MIN_SCALE:       cfg_shadow.min_scale       = val;
            REG_MAX_SCALE:       cfg_shadow.max_scale       = val;
            REG_EXTENT_X:        cfg_shadow.extent_x        = val[EXT_W-1:0];
            REG_EXTENT_Y:        cfg_shadow.extent_y        = val[EXT_W-1:0];
            REG_EXTENT_Z:        cfg_shadow.extent_z        = val[EXT_W-1:0];
            REG_BOUNDS_VALID:    cfg_shadow.bounds_valid    = val[0];
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [31:0] tf, input logic [31:0] mn, input logic [31:0] mx,
                             input logic [31:0] ex, input logic [31:0] ey, input logic [31:0] ez,
                             input logic [31:0] bv);
        write_reg(REG_SPAN_RATIO, tf);
        write_reg(REG_MIN_SCALE, mn);
        write_reg(REG_MAX_SCALE, mx);
        write_reg(REG_EXTENT_X, ex);
        write_reg(REG_EXTENT_Y, ey);
        write_reg(REG_EXTENT_Z, ez);
        write_reg(REG_BOUNDS_VALID, bv);
        cfg_phases++;
    endtask

    task automatic push_beat(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z,
                             input logic fin, input logic last);
        vec_beat_t b;
        while (vec_queue.size() >= 32)
            @(posedge clk);
        b.x = x;
        b.y = y;
        b.z = z;
        b.fin = fin;
        b.last = last;
        vec_queue.push_back(b);
        beats_pushed++;
    endtask

    function automatic logic [15:0] rand_comp();
        int r;
        r = $urandom_range(99);
        if (r < 15)
        begin
            case ($urandom_range(3))
                0: return 16'h8000;
                1: return 16'h7FFF;
                2: return 16'h0000;
                default: return 16'hFFFF;
            endcase
        end
        if (r < 40)
            return 16'($urandom_range(127)) - 16'd64;
        return 16'($urandom);
    endfunction

    // Wait until every queued beat is taken and every result has come back
    task automatic settle();
        @(posedge clk);
        while (beats_accepted != beats_pushed || expected_stats.size() != 0)
            @(posedge clk);
        repeat (250) @(posedge clk);
    endtask

    task automatic rand_config();
        logic [31:0] tf;
        logic [31:0] mn;
        logic [31:0] mx;
        logic [31:0] ext[3];
        int r;
        r = $urandom_range(99);
        if (r < 8)
            tf = 0;
        else if (r < 16)
            tf = 32'hFF_FFFF;
        else if (r < 30)
            tf = $urandom & 32'hFF_FFFF;
        else
            tf = $urandom_range(32'h30000, 1);
        r = $urandom_range(99);
        if (r < 60)
            mn = 0;
        else if (r < 85)
            mn = $urandom_range(32'h40000, 0);
        else if (r < 95)
            mn = $urandom;
        else
            mn = 32'hFFFF_FFFF;
        r = $urandom_range(99);
        if (r < 55)
            mx = 32'hFFFF_FFFF;
        else if (r < 80)
            mx = (mn > 32'hFFEF_FFFF) ? 32'hFFFF_FFFF : mn + $urandom_range(32'h100000, 0);
        else if (r < 95)
            mx = $urandom;
        else
            mx = 0;
        for (int i = 0; i < 3; i++)
        begin
            r = $urandom_range(99);
            if (r < 10)
                ext[i] = 0;
            else if (r < 20)
                ext[i] = 32'hFFFF;
            else
                ext[i] = $urandom & 32'hFFFF;
        end
        if ($urandom_range(99) < 8)
        begin
            ext[0] = 0;
            ext[1] = 0;
            ext[2] = 0;
        end
        write_all(tf, mn, mx, ext[0], ext[1], ext[2], ($urandom_range(99) < 85) ? 1 : 0);
    endtask

    initial
    begin : stimulus
        int nsets;
        int len;
        int r;
        int wait_cycles;
        cfg_shadow.span_ratio      = 24'd6554;
        cfg_shadow.min_scale       = 32'd0;
        cfg_shadow.max_scale       = 32'hFFFF_FFFF;
        cfg_shadow.extent_x        = '0;
        cfg_shadow.extent_y        = '0;
        cfg_shadow.extent_z        = '0;
        cfg_shadow.bounds_valid    = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset settings: bounds not valid, so status reports a bounds error
        push_beat(16'h8000, 16'h8000, 16'h8000, 1'b1, 1'b0);
        push_beat(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1, 1'b0);
        push_beat(rand_comp(), rand_comp(), rand_comp(), 1'b0, 1'b0);
        push_beat(16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1);
        push_beat(rand_comp(), rand_comp(), rand_comp(), 1'b0, 1'b1);   // nothing finite
        settle();

        // Zero diagonal, then zero peak: both fall back to unit scale
        write_all(6554, 0, 32'hFFFF_FFFF, 0, 0, 0, 1);
        push_beat(16'd100, -16'sd200, 16'd300, 1'b1, 1'b1);
        settle();
        write_reg(REG_EXTENT_X, 32'd1200);
        push_beat(16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0);
        push_beat(16'h8000, 16'h7FFF, 16'h1234, 1'b0, 1'b1);
        settle();

        // Largest fraction and diagonal over a tiny peak saturates
        write_all(32'hFF_FFFF, 0, 32'hFFFF_FFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF, 1);
        push_beat(16'd1, 16'd0, 16'd0, 1'b1, 1'b1);
        push_beat(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
        push_beat(16'd5, 16'd5, 16'd5, 1'b1, 1'b1);
        settle();

        // Bad arguments: zero fraction, then max below min
        write_reg(REG_SPAN_RATIO, 0);
        push_beat(rand_comp(), rand_comp(), rand_comp(), 1'b1, 1'b1);
        settle();
        write_all(32'h10000, 32'h20000, 32'h10000, 1000, 2000, 3000, 1);
        push_beat(rand_comp(), rand_comp(), rand_comp(), 1'b1, 1'b1);
        settle();

        // Clamping against both limits
        write_all(32'h10000, 32'h30000, 32'h40000, 1000, 2000, 3000, 1);
        push_beat(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1, 1'b1);
        push_beat(16'd1, 16'd1, 16'd1, 1'b1, 1'b1);
        settle();

        // Random phases: new settings, then a handful of sets of mostly short length
        while (beats_pushed < 400)
        begin
            rand_config();
            nsets = $urandom_range(12, 4);
            for (int s = 0; s < nsets; s++)
            begin
                r = $urandom_range(99);
                if (r < 70)
                    len = $urandom_range(6, 1);
                else if (r < 95)
                    len = $urandom_range(20, 7);
                else
                    len = $urandom_range(60, 30);
                for (int i = 0; i < len; i++)
                    push_beat(rand_comp(), rand_comp(), rand_comp(),
                              ($urandom_range(99) < 85), (i == len - 1));
            end
            settle();
        end

        // One longer set at full rate with no gaps, then a short set right behind it
        gaps_on = 1'b0;
        write_all(6554, 0, 32'hFFFF_FFFF, 300, 400, 500, 1);
        for (int i = 0; i < 24; i++)
            push_beat(rand_comp(), rand_comp(), rand_comp(), 1'b1, (i == 23));
        push_beat(16'd3, 16'd4, 16'd0, 1'b1, 1'b1);

        @(posedge clk);
        while (beats_accepted != beats_pushed)
            @(posedge clk);
        wait_cycles = 0;
        while (expected_stats.size() != 0 && wait_cycles < 5000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (250) @(posedge clk);
        if (expected_stats.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $realtime, expected_stats.size());
            mismatch_count += expected_stats.size();
        end
        $display("Checked %0d result beats from %0d input beats over %0d register settings,",
                 results_seen, beats_accepted, cfg_phases);
        $display("covering error codes, clamping, saturation and back-to-back beats.");
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Timeout: %0d beats accepted, %0d results pending",
                 beats_accepted, expected_stats.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
